// File: hw/rtl/fixed_point_alu_rounding_macros.svh
// assertion macros used by the alu back stages
// expects clk and rst_n in the scope of use
`ifndef FIXED_POINT_ALU_ROUNDING_MACROS_SVH
`define FIXED_POINT_ALU_ROUNDING_MACROS_SVH

// same-cycle implication
`define FPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpa assertion failed");

// next-cycle implication
`define FPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpa assertion failed");

`endif

// File: hw/rtl/fpa_pkg.sv
// shared types, codes and helper functions of the fixed-point alu
// no dependencies
package fpa_pkg;

    localparam int DataWidth = 32;
    localparam int NumBits   = 63;

    localparam logic [1:0] OpAdd = 2'd0;
    localparam logic [1:0] OpSub = 2'd1;
    localparam logic [1:0] OpMul = 2'd2;
    localparam logic [1:0] OpDiv = 2'd3;

    localparam logic [1:0] RndZero = 2'd0;
    localparam logic [1:0] RndEven = 2'd1;
    localparam logic [1:0] RndPos  = 2'd2;
    localparam logic [1:0] RndNeg  = 2'd3;

    localparam logic [1:0] RegIntBits  = 2'd0;
    localparam logic [1:0] RegFracBits = 2'd1;
    localparam logic [1:0] RegRndMode  = 2'd2;

    typedef struct packed {
        logic [5:0] int_bits;
        logic [4:0] frac_bits;
        logic [1:0] mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        neg;
        logic        bzero;
        logic [31:0] addsub;
        logic [63:0] prod;
        logic [62:0] num;
        logic [31:0] lb;
    } front_word_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        neg;
        logic        dz;
        logic [31:0] other;
        logic [31:0] lb;
        logic [62:0] num;
        logic [31:0] rem;
        logic [31:0] quo;
    } div_word_t;

    typedef struct packed {
        logic [31:0] mag;
        logic        neg_apply;
        logic        dz;
    } back_word_t;

    function automatic logic [5:0] fmt_width(cfg_t c);
        logic [6:0] sum;
        logic [5:0] w;
        sum = {1'b0, c.int_bits} + {2'b00, c.frac_bits};
        if (sum > 7'(DataWidth))
        begin
            w = 6'(DataWidth);
        end
        else if (sum == 7'd0)
        begin
            w = 6'd1;
        end
        else
        begin
            w = sum[5:0];
        end
        return w;
    endfunction

    // keep the low w bits and sign-extend from bit w-1
    function automatic logic [31:0] wrap_ext(logic [31:0] v, logic [5:0] w);
        logic [31:0] o;
        logic        s;
        s = v[5'(w - 6'd1)];
        for (int i = 0; i < 32; i++)
        begin
            o[i] = (i < int'(w)) ? v[i] : s;
        end
        return o;
    endfunction

    function automatic logic round_inc(logic [1:0] mode, logic q0, logic rnz,
                                       logic gt, logic eq, logic neg);
        logic inc;
        case (mode)
            RndEven: inc = gt | (eq & q0);
            RndPos:  inc = rnz & ~neg;
            RndNeg:  inc = rnz & neg;
            default: inc = 1'b0;
        endcase
        return inc;
    endfunction

    // one restoring division step, shifting in numerator bit nbit
    function automatic div_word_t div_step(div_word_t d, logic nbit);
        div_word_t   o;
        logic [32:0] t;
        logic [32:0] diff;
        logic        ge;
        o    = d;
        t    = {d.rem, nbit};
        diff = t - {1'b0, d.lb};
        ge   = (t >= {1'b0, d.lb});
        o.rem = ge ? diff[31:0] : t[31:0];
        o.quo = {d.quo[30:0], ge};
        return o;
    endfunction

endpackage

// File: hw/rtl/fpa_cfg.sv
// apb register file: format and rounding mode
// depends on fpa_pkg
module fpa_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output fpa_pkg::cfg_t cfg
);

    fpa_pkg::cfg_t cfg_reg;
    fpa_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                fpa_pkg::RegIntBits:  cfg_next.int_bits  = pwdata[5:0];
                fpa_pkg::RegFracBits: cfg_next.frac_bits = pwdata[4:0];
                fpa_pkg::RegRndMode:  cfg_next.mode      = pwdata[1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.int_bits  <= 6'd16;
            cfg_reg.frac_bits <= 5'd16;
            cfg_reg.mode      <= fpa_pkg::RndZero;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fpa_pkg::RegIntBits:  prdata = {26'd0, cfg_reg.int_bits};
            fpa_pkg::RegFracBits: prdata = {27'd0, cfg_reg.frac_bits};
            fpa_pkg::RegRndMode:  prdata = {30'd0, cfg_reg.mode};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

// File: hw/rtl/fpa_front.sv
// front stages: operand capture, format reduction, magnitudes, add/sub, multiply
// depends on fpa_pkg
module fpa_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  fpa_pkg::cfg_t       cfg,
    input  logic                in_vld,
    input  logic [1:0]          req_type,
    input  logic signed [31:0]  operand_a,
    input  logic signed [31:0]  operand_b,
    output logic                out_vld,
    output fpa_pkg::front_word_t out_word
);

    logic        s1_vld_reg;
    logic [1:0]  s1_op_reg;
    logic [31:0] s1_a_reg;
    logic [31:0] s1_b_reg;

    logic        s2_vld_reg;
    logic [1:0]  s2_op_reg;
    logic        s2_neg_reg;
    logic        s2_bzero_reg;
    logic [31:0] s2_addsub_reg;
    logic [31:0] s2_la_reg;
    logic [31:0] s2_lb_reg;

    logic                 s3_vld_reg;
    fpa_pkg::front_word_t s3_word_reg;
    fpa_pkg::front_word_t s3_word_next;

    logic [5:0]  w;
    logic [31:0] ae;
    logic [31:0] be;
    logic [31:0] la_next;
    logic [31:0] lb_next;
    logic [31:0] sum;
    logic [31:0] dif;

    assign w   = fpa_pkg::fmt_width(cfg);
    assign ae  = fpa_pkg::wrap_ext(s1_a_reg, w);
    assign be  = fpa_pkg::wrap_ext(s1_b_reg, w);
    assign la_next = ae[31] ? (32'd0 - ae) : ae;
    assign lb_next = be[31] ? (32'd0 - be) : be;
    assign sum = fpa_pkg::wrap_ext(ae + be, w);
    assign dif = fpa_pkg::wrap_ext(ae - be, w);

    always_comb
    begin
        s3_word_next.op     = s2_op_reg;
        s3_word_next.neg    = s2_neg_reg;
        s3_word_next.bzero  = s2_bzero_reg;
        s3_word_next.addsub = s2_addsub_reg;
        s3_word_next.prod   = {32'd0, s2_la_reg} * {32'd0, s2_lb_reg};
        s3_word_next.num    = {31'd0, s2_la_reg} << cfg.frac_bits;
        s3_word_next.lb     = s2_lb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg     <= req_type;
            s1_a_reg      <= operand_a;
            s1_b_reg      <= operand_b;
            s2_op_reg     <= s1_op_reg;
            s2_neg_reg    <= ae[31] ^ be[31];
            s2_bzero_reg  <= (be == 32'd0);
            s2_addsub_reg <= (s1_op_reg == fpa_pkg::OpAdd) ? sum : dif;
            s2_la_reg     <= la_next;
            s2_lb_reg     <= lb_next;
            s3_word_reg   <= s3_word_next;
        end
    end

    assign out_vld  = s3_vld_reg;
    assign out_word = s3_word_reg;

endmodule

// File: hw/rtl/fpa_div.sv
// pipelined restoring divider, one quotient bit per stage; also rounds the product
// depends on fpa_pkg
module fpa_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  fpa_pkg::cfg_t        cfg,
    input  logic                 in_vld,
    input  fpa_pkg::front_word_t in_word,
    output logic                 out_vld,
    output fpa_pkg::div_word_t   out_word
);

    logic               vld_reg  [fpa_pkg::NumBits];
    fpa_pkg::div_word_t word_reg [fpa_pkg::NumBits];
    fpa_pkg::div_word_t head;

    logic [63:0] rmask;
    logic [63:0] rpart;
    logic [63:0] half;
    logic [31:0] mq;
    logic        minc;

    // product rounding, divisor is 2^frac
    assign half  = 64'd1 << cfg.frac_bits;
    assign rmask = half - 64'd1;
    assign rpart = in_word.prod & rmask;
    assign mq    = 32'(in_word.prod >> cfg.frac_bits);
    assign minc  = fpa_pkg::round_inc(cfg.mode, mq[0], rpart != 64'd0,
                                      (rpart << 1) > half, (rpart << 1) == half,
                                      in_word.neg);

    always_comb
    begin
        head.op    = in_word.op;
        head.neg   = in_word.neg;
        head.dz    = in_word.bzero;
        head.other = (in_word.op == fpa_pkg::OpMul) ? (mq + {31'd0, minc}) : in_word.addsub;
        head.lb    = in_word.lb;
        head.num   = in_word.num;
        head.rem   = 32'd0;
        head.quo   = 32'd0;
    end

    for (genvar j = 0; j < fpa_pkg::NumBits; j++)
    begin : g_stage
        if (j == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[j] <= 1'b0;
                end
                else if (advance)
                begin
                    vld_reg[j] <= in_vld;
                end
            end
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    word_reg[j] <= fpa_pkg::div_step(head, head.num[fpa_pkg::NumBits - 1]);
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[j] <= 1'b0;
                end
                else if (advance)
                begin
                    vld_reg[j] <= vld_reg[j-1];
                end
            end
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    word_reg[j] <= fpa_pkg::div_step(word_reg[j-1],
                        word_reg[j-1].num[fpa_pkg::NumBits - 1 - j]);
                end
            end
        end
    end

    assign out_vld  = vld_reg[fpa_pkg::NumBits - 1];
    assign out_word = word_reg[fpa_pkg::NumBits - 1];

endmodule

// File: hw/rtl/fpa_back.sv
// back stages: quotient rounding, sign restore, wrap and output register
// depends on fpa_pkg and the macros header
`include "fixed_point_alu_rounding_macros.svh"
module fpa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  fpa_pkg::cfg_t      cfg,
    input  logic               in_vld,
    input  fpa_pkg::div_word_t in_word,
    output logic               out_vld,
    output logic signed [31:0] result_value,
    output logic               div_by_zero
);

    logic                f1_vld_reg;
    fpa_pkg::back_word_t f1_reg;
    fpa_pkg::back_word_t f1_next;

    logic        o_vld_reg;
    logic [31:0] o_res_reg;
    logic        o_dz_reg;
    logic [31:0] o_res_next;
    logic [31:0] signed_mag;

    logic        is_div;
    logic        dinc;

    assign is_div = (in_word.op == fpa_pkg::OpDiv);
    assign dinc   = fpa_pkg::round_inc(cfg.mode, in_word.quo[0], in_word.rem != 32'd0,
                                       {in_word.rem, 1'b0} > {1'b0, in_word.lb},
                                       {in_word.rem, 1'b0} == {1'b0, in_word.lb},
                                       in_word.neg);

    always_comb
    begin
        f1_next.mag       = is_div ? (in_word.quo + {31'd0, dinc}) : in_word.other;
        f1_next.neg_apply = in_word.neg & ((in_word.op == fpa_pkg::OpMul) | is_div);
        f1_next.dz        = is_div & in_word.dz;
    end

    assign signed_mag = f1_reg.neg_apply ? (32'd0 - f1_reg.mag) : f1_reg.mag;
    assign o_res_next = f1_reg.dz ? 32'd0
                                  : fpa_pkg::wrap_ext(signed_mag, fpa_pkg::fmt_width(cfg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else if (advance)
        begin
            f1_vld_reg <= in_vld;
            o_vld_reg  <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_reg    <= f1_next;
            o_res_reg <= o_res_next;
            o_dz_reg  <= f1_reg.dz;
        end
    end

    assign out_vld      = o_vld_reg;
    assign result_value = o_res_reg;
    assign div_by_zero  = o_dz_reg;

    `FPA_ASSERT_NOW(a_dz_zero, o_vld_reg && o_dz_reg, o_res_reg == 32'd0)
    `FPA_ASSERT_NEXT(a_stall_holds, !advance, $stable(f1_vld_reg) && $stable(o_vld_reg))
    `FPA_ASSERT_NEXT(a_moves_on, advance && f1_vld_reg, o_vld_reg)
    `FPA_ASSERT_NOW(a_stall_only_full, !advance, o_vld_reg)

endmodule

// File: hw/rtl/fixed_point_alu_rounding.sv
// an accepted word travels to its result word through the stages
// (3 front stages, 63 divider stages, rounding stage, output register)
// one word per cycle unless stalled; every operation walks the same pipeline
// a stall freezes all stages together while the output word waits
// rst_n clears all valid bits and loads int_bits 16, frac_bits 16, round toward zero
module fixed_point_alu_rounding (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_value,
    output logic               div_by_zero
);

    fpa_pkg::cfg_t        cfg;
    fpa_pkg::front_word_t front_word;
    fpa_pkg::div_word_t   div_word;
    logic                 front_vld;
    logic                 div_vld;
    logic                 advance;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    fpa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg),
        .in_vld    (in_valid),
        .req_type  (req_type),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_vld   (front_vld),
        .out_word  (front_word)
    );

    fpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cfg      (cfg),
        .in_vld   (front_vld),
        .in_word  (front_word),
        .out_vld  (div_vld),
        .out_word (div_word)
    );

    fpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .cfg          (cfg),
        .in_vld       (div_vld),
        .in_word      (div_word),
        .out_vld      (out_valid),
        .result_value (result_value),
        .div_by_zero  (div_by_zero)
    );

endmodule
